/* rtl/midpoint_filled_circle_spans_top_defines.svh */
// assertion macros for the filled circle span generator checker
// depends on clk and arst_n being visible where the macros are used
`ifndef MIDPOINT_FILLED_CIRCLE_SPANS_TOP_DEFINES_SVH
`define MIDPOINT_FILLED_CIRCLE_SPANS_TOP_DEFINES_SVH

// same-cycle implication
`define MFCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mfcs_pkg.sv */
// shared types and constants for the filled circle span generator
// no dependencies
package mfcs_pkg;

	localparam int MAX_RADIUS      = 4095;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IMG_LIMIT       = 4096;

	localparam logic [0:0]  REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0]  REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd1024;
	localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd768;

	typedef enum logic [1:0] {
		JOB_START,
		JOB_STEP,
		JOB_FINISHED
	} job_kind_t;

	typedef logic signed [14:0] coord_t;

	typedef struct packed {
		job_kind_t          kind;
		logic               outer;
		logic               done;
		logic signed [13:0] cx;
		logic signed [13:0] cy;
		logic [31:0]        color;
		logic [11:0]        px;
		logic [11:0]        py;
		logic [11:0]        nx;
		logic [11:0]        ny;
	} job_t;

endpackage

/* rtl/mfcs_front.sv */
// front end: accepts beats, runs the midpoint iteration, builds span jobs
// depends on mfcs_pkg
module mfcs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic signed [13:0]  center_col,
	input  logic signed [13:0]  center_row,
	input  logic [11:0]         circle_radius,
	input  logic [31:0]         fill_color,
	input  logic                queue_full,
	output logic                push,
	output mfcs_pkg::job_t      job
);
	import mfcs_pkg::*;

	logic [11:0]        step_x_q;
	logic [11:0]        step_y_q;
	logic [15:0]        decision_q;
	logic signed [13:0] held_col_q;
	logic signed [13:0] held_row_q;
	logic [31:0]        held_color_q;

	logic [11:0] r_sat;
	logic [11:0] x_inc;
	logic [11:0] y_dec;
	logic [11:0] y_new;
	logic [15:0] diff;
	logic [15:0] d_new;
	logic        outer;
	logic        finished;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		r_sat    = (int'(circle_radius) > MAX_RADIUS) ? 12'(MAX_RADIUS) : circle_radius;
		outer    = !decision_q[15];
		finished = !(step_x_q < step_y_q);
		x_inc    = step_x_q + 12'd1;
		y_dec    = step_y_q - 12'd1;
		y_new    = outer ? y_dec : step_y_q;
		diff     = {4'b0, step_x_q} - {4'b0, y_dec};
		if (outer) begin
			d_new = decision_q + {diff[14:0], 1'b0} + 16'd5;
		end else begin
			d_new = decision_q + {3'b0, step_x_q, 1'b0} + 16'd3;
		end
	end

	always_comb begin
		job       = '0;
		job.cx    = held_col_q;
		job.cy    = held_row_q;
		job.color = held_color_q;
		if (!cmd) begin
			job.kind  = JOB_START;
			job.cx    = center_col;
			job.cy    = center_row;
			job.color = fill_color;
			job.nx    = '0;
			job.ny    = r_sat;
			job.done  = (r_sat == 12'd0);
		end else if (finished) begin
			job.kind = JOB_FINISHED;
			job.done = 1'b1;
		end else begin
			job.kind  = JOB_STEP;
			job.outer = outer;
			job.px    = step_x_q;
			job.py    = step_y_q;
			job.nx    = x_inc;
			job.ny    = y_new;
			job.done  = !(x_inc < y_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q     <= '0;
			step_y_q     <= '0;
			decision_q   <= '0;
			held_col_q   <= '0;
			held_row_q   <= '0;
			held_color_q <= '0;
		end else if (push) begin
			if (!cmd) begin
				step_x_q     <= '0;
				step_y_q     <= r_sat;
				decision_q   <= 16'd1 - {4'b0, r_sat};
				held_col_q   <= center_col;
				held_row_q   <= center_row;
				held_color_q <= fill_color;
			end else if (!finished) begin
				step_x_q   <= x_inc;
				step_y_q   <= y_new;
				decision_q <= d_new;
			end
		end
	end

endmodule

/* rtl/mfcs_queue.sv */
// job queue between the front and back ends
// depends on mfcs_pkg
module mfcs_queue #(
	parameter int DEPTH = mfcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfcs_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mfcs_pkg::job_t rd_job
);
	import mfcs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/mfcs_back.sv */
// back end: walks each job's spans, clips them and drives the output register
// depends on mfcs_pkg
module mfcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  mfcs_pkg::job_t job,
	output logic           pop,
	input  logic [12:0]    image_width,
	input  logic [12:0]    image_height,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [71:0]    m_tdata,  // row, left, right, color, zero pad
	output logic [1:0]     m_tuser,  // span_valid, circle_done
	output logic           m_tlast
);
	import mfcs_pkg::*;

	localparam logic [1:0] IDX_OUTER_HI = 2'd0;
	localparam logic [1:0] IDX_OUTER_LO = 2'd1;
	localparam logic [1:0] IDX_INNER_HI = 2'd2;
	localparam logic [1:0] IDX_INNER_LO = 2'd3;

	logic [1:0] cnt_q;
	logic [1:0] first_idx;
	logic [1:0] last_idx;
	logic [1:0] eff_idx;
	logic       is_last;
	logic       issue;
	logic       s1_load;
	logic       out_load;

	logic [11:0] off;
	logic [11:0] hw;
	logic        neg;
	coord_t      cx_e;
	coord_t      cy_e;
	coord_t      row_raw;
	coord_t      lo_raw;
	coord_t      hi_raw;

	logic        valid_s1;
	logic        inv_s1;
	coord_t      row_s1;
	coord_t      lo_s1;
	coord_t      hi_s1;
	logic [31:0] color_s1;
	logic        last_s1;
	logic        done_s1;

	logic [12:0] w_eff;
	logic [12:0] h_eff;
	coord_t      wc;
	coord_t      hc;
	logic        ok;
	coord_t      lo_c;
	coord_t      hi_c;

	logic        m_valid_q;
	logic        m_ok_q;
	logic [11:0] m_row_q;
	logic [11:0] m_left_q;
	logic [11:0] m_right_q;
	logic [31:0] m_color_q;
	logic        m_last_q;
	logic        m_done_q;

	always_comb begin
		unique case (job.kind) inside
			JOB_STEP: begin
				first_idx = job.outer ? IDX_OUTER_HI : IDX_INNER_HI;
				last_idx  = IDX_INNER_LO;
			end
			JOB_START, JOB_FINISHED: begin
				first_idx = IDX_INNER_HI;
				last_idx  = IDX_INNER_HI;
			end
			default: begin
				first_idx = IDX_INNER_HI;
				last_idx  = IDX_INNER_HI;
			end
		endcase
		eff_idx = first_idx + cnt_q;
		is_last = (eff_idx == last_idx);
	end

	assign out_load = !m_valid_q || m_tready;
	assign s1_load  = !valid_s1 || out_load;
	assign issue    = job_valid && s1_load;
	assign pop      = issue && is_last;

	always_comb begin
		unique case (eff_idx)
			IDX_OUTER_HI: begin off = job.py; neg = 1'b0; hw = job.px; end
			IDX_OUTER_LO: begin off = job.py; neg = 1'b1; hw = job.px; end
			IDX_INNER_HI: begin off = job.nx; neg = 1'b0; hw = job.ny; end
			IDX_INNER_LO: begin off = job.nx; neg = 1'b1; hw = job.ny; end
			default:      begin off = job.nx; neg = 1'b0; hw = job.ny; end
		endcase
		cx_e    = coord_t'(job.cx);
		cy_e    = coord_t'(job.cy);
		row_raw = neg ? cy_e - $signed({3'b0, off}) : cy_e + $signed({3'b0, off});
		lo_raw  = cx_e - $signed({3'b0, hw});
		hi_raw  = cx_e + $signed({3'b0, hw});
	end

	// span sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				cnt_q <= is_last ? 2'd0 : cnt_q + 2'd1;
			end
			if (s1_load) begin
				valid_s1 <= job_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			inv_s1   <= (job.kind == JOB_FINISHED);
			row_s1   <= row_raw;
			lo_s1    <= lo_raw;
			hi_s1    <= hi_raw;
			color_s1 <= job.color;
			last_s1  <= is_last;
			done_s1  <= job.done;
		end
	end

	// clipping
	always_comb begin
		w_eff = (image_width > 13'(IMG_LIMIT)) ? 13'(IMG_LIMIT) : image_width;
		h_eff = (image_height > 13'(IMG_LIMIT)) ? 13'(IMG_LIMIT) : image_height;
		wc    = $signed({2'b0, w_eff});
		hc    = $signed({2'b0, h_eff});
		ok    = !inv_s1 && !row_s1[14] && (row_s1 < hc) && !hi_s1[14] && (lo_s1 < wc);
		lo_c  = lo_s1[14] ? '0 : lo_s1;
		hi_c  = (hi_s1 > wc - 15'sd1) ? wc - 15'sd1 : hi_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			m_ok_q    <= ok;
			m_row_q   <= ok ? row_s1[11:0] : '0;
			m_left_q  <= ok ? lo_c[11:0] : '0;
			m_right_q <= ok ? hi_c[11:0] : '0;
			m_color_q <= ok ? color_s1 : '0;
			m_last_q  <= last_s1;
			m_done_q  <= done_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, m_color_q, m_right_q, m_left_q, m_row_q};
	assign m_tuser  = {m_done_q, m_ok_q};
	assign m_tlast  = m_last_q;

endmodule

/* rtl/midpoint_filled_circle_spans_top.sv */
// filled circle span generator, midpoint scheme
// a span beat passes the queue slot, the stage-1 registers and the output register before it shows on m_tvalid
// a start, or a step after done, yields one span beat, an inner step two and an outer step four
// the back end sends one span per cycle while m_tready is high, the front runs ahead by up to QUEUE_DEPTH jobs
// reset: clears circle state and queue, image size returns to 1024 x 768
module midpoint_filled_circle_spans_top #(
	parameter int QUEUE_DEPTH = mfcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // center_col, center_row, circle_radius, fill_color
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // span_row, span_left, span_right, span_color, zero pad
	output logic [1:0]  m_tuser,  // span_valid, circle_done
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import mfcs_pkg::*;

	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	job_t        wr_job;
	job_t        rd_job;
	logic        push;
	logic        pop;
	logic        full;
	logic        not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mfcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.cmd          (s_tuser),
		.center_col   ($signed(s_tdata[13:0])),
		.center_row   ($signed(s_tdata[27:14])),
		.circle_radius(s_tdata[39:28]),
		.fill_color   (s_tdata[71:40]),
		.queue_full   (full),
		.push         (push),
		.job          (wr_job)
	);

	mfcs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.rd_job   (rd_job)
	);

	mfcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (not_empty),
		.job         (rd_job),
		.pop         (pop),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

/* rtl/mfcs_checker.sv */
// port-level checks for the filled circle span generator
// depends on midpoint_filled_circle_spans_top_defines.svh, bound to the top level
`include "midpoint_filled_circle_spans_top_defines.svh"

module mfcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	`MFCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled span beat changed")
	`MFCS_ASSERT_IMPLY(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == 72'd0, "invalid span carries payload")
	`MFCS_ASSERT_IMPLY(a_left_le_right, m_tvalid && m_tuser[0], m_tdata[23:12] <= m_tdata[35:24], "clipped span left beyond right")

endmodule

bind midpoint_filled_circle_spans_top mfcs_checker u_mfcs_checker (.*);
